FILE: hdl/evsc_pkg.sv
`default_nettype none
package evsc_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] RegSuperheatTarget   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegCriticalLowLimit  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegCriticalCloseStep = 3'd2;
	localparam logic [CfgIdxW-1:0] RegHighLimit         = 3'd3;
	localparam logic [CfgIdxW-1:0] RegLowLimit          = 3'd4;
	localparam logic [CfgIdxW-1:0] RegWaitAfterOpen     = 3'd5;
	localparam logic [CfgIdxW-1:0] RegWaitAfterClose    = 3'd6;
	localparam logic [CfgIdxW-1:0] RegDischargeTempLim  = 3'd7;

	// Operating modes.
	localparam logic [1:0] ModeDirect   = 2'd0;
	localparam logic [1:0] ModeRegulate = 2'd1;
	localparam logic [1:0] ModeStartup  = 2'd2;
	localparam logic [1:0] ModePumpDown = 2'd3;

	// Action codes reported with each result.
	localparam logic [3:0] ActDirect      = 4'd0;
	localparam logic [3:0] ActOvertemp    = 4'd1;
	localparam logic [3:0] ActCriticalLow = 4'd2;
	localparam logic [3:0] ActWaiting     = 4'd3;
	localparam logic [3:0] ActOpened      = 4'd4;
	localparam logic [3:0] ActClosed      = 4'd5;
	localparam logic [3:0] ActInBand      = 4'd6;
	localparam logic [3:0] ActStartup     = 4'd7;
	localparam logic [3:0] ActPumpDown    = 4'd8;

	// Openings in 0.1 percent units.
	localparam logic [9:0] OpenMax        = 10'd1000;
	localparam logic [9:0] StartupOpening = 10'd500;
	localparam logic [9:0] OvertempStep   = 10'd50;
	localparam logic [9:0] FineStep       = 10'd10;

	typedef struct packed {
		logic [8:0]         superheat_target;
		logic signed [9:0]  critical_low_limit;
		logic [9:0]         critical_close_step;
		logic signed [10:0] high_limit;
		logic signed [10:0] low_limit;
		logic [15:0]        wait_after_open;
		logic [15:0]        wait_after_close;
		logic [10:0]        discharge_temp_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [11:0] target_discharge_temp;
		logic signed [11:0] measured_discharge_temp;
		logic [9:0]         opening_setpoint;
	} item_t;

	typedef struct packed {
		logic [9:0]  opening;
		logic        wait_active;
		logic [15:0] wait_count;
		logic        pumped_down;
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/evsc_if.sv
`default_nettype none
interface evsc_tick_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [11:0] target_discharge_temp;
	logic signed [11:0] measured_discharge_temp;
	logic [9:0]         opening_setpoint;

	modport source(output valid, output mode, output target_discharge_temp,
		output measured_discharge_temp, output opening_setpoint, input ready);
	modport sink(input valid, input mode, input target_discharge_temp,
		input measured_discharge_temp, input opening_setpoint, output ready);
endinterface

interface evsc_result_if;
	logic       valid;
	logic       ready;
	logic [9:0] valve_opening;
	logic       holding;
	logic       pump_down;
	logic [3:0] action;

	modport source(output valid, output valve_opening, output holding,
		output pump_down, output action, input ready);
	modport sink(input valid, input valve_opening, input holding,
		input pump_down, input action, output ready);
endinterface

interface evsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/expansion_valve_superheat_control.sv
// Throughput: one request per cycle while the result sink keeps up. A request
// in the input register moves into the result register, and the controller state
// is updated by the single compute stage between these two registers.
// Reset (arst_n low) clears the valve state, both pipeline valids and restores the
// configuration registers to their documented defaults.
`default_nettype none
module expansion_valve_superheat_control (
	input  wire logic      clk,
	input  wire logic      arst_n,
	evsc_tick_if.sink      tick,
	evsc_result_if.source  result,
	evsc_cfg_if.sink       cfg
);

	evsc_pkg::cfg_t   regs;
	evsc_pkg::item_t  item_s1;
	logic             valid_s1;
	evsc_pkg::state_t state_q;
	evsc_pkg::state_t state_nxt;
	logic [3:0]       action_nxt;
	logic             advance;
	logic             out_valid_q;
	logic [3:0]       action_q;

	evsc_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.regs  (regs)
	);

	evsc_step u_step (
		.regs  (regs),
		.item  (item_s1),
		.cur   (state_q),
		.nxt   (state_nxt),
		.action(action_nxt)
	);

	// The result register frees up in the same cycle it is taken, so the
	// input register can move on every cycle while the sink keeps up.
	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			item_s1.mode <= tick.mode;
			item_s1.target_discharge_temp <= tick.target_discharge_temp;
			item_s1.measured_discharge_temp <= tick.measured_discharge_temp;
			item_s1.opening_setpoint <= tick.opening_setpoint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			out_valid_q <= advance || (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= action_nxt;
		end
	end

	// The state register doubles as the result payload.
	assign result.valid = out_valid_q;
	assign result.valve_opening = state_q.opening;
	assign result.holding = state_q.wait_active;
	assign result.pump_down = state_q.pumped_down;
	assign result.action = action_q;

	a_opening_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.opening <= evsc_pkg::OpenMax)
		else $error("valve opening above full scale");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.wait_active |-> state_q.wait_count == 16'd0)
		else $error("wait count left nonzero without an active wait");

	a_in_band_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_nxt == evsc_pkg::ActInBand |=> $stable(state_q))
		else $error("in-band tick changed the controller state");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("controller state changed without a request");

	a_pump_down_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_nxt == evsc_pkg::ActPumpDown |=>
		state_q.opening == 10'd0 && state_q.pumped_down)
		else $error("pump-down did not close the valve");

endmodule
`default_nettype wire

FILE: hdl/evsc_cfg_regs.sv
`default_nettype none
module evsc_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	evsc_cfg_if.sink           cfg,
	output evsc_pkg::cfg_t     regs
);

	evsc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.superheat_target     <= 9'd60;
			regs_q.critical_low_limit   <= 10'sd20;
			regs_q.critical_close_step  <= 10'd50;
			regs_q.high_limit           <= 11'sd100;
			regs_q.low_limit            <= 11'sd40;
			regs_q.wait_after_open      <= 16'd10;
			regs_q.wait_after_close     <= 16'd10;
			regs_q.discharge_temp_limit <= 11'd1300;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				evsc_pkg::RegSuperheatTarget:   regs_q.superheat_target <= cfg.data[8:0];
				evsc_pkg::RegCriticalLowLimit:  regs_q.critical_low_limit <= cfg.data[9:0];
				evsc_pkg::RegCriticalCloseStep: regs_q.critical_close_step <= cfg.data[9:0];
				evsc_pkg::RegHighLimit:         regs_q.high_limit <= cfg.data[10:0];
				evsc_pkg::RegLowLimit:          regs_q.low_limit <= cfg.data[10:0];
				evsc_pkg::RegWaitAfterOpen:     regs_q.wait_after_open <= cfg.data;
				evsc_pkg::RegWaitAfterClose:    regs_q.wait_after_close <= cfg.data;
				evsc_pkg::RegDischargeTempLim:  regs_q.discharge_temp_limit <= cfg.data[10:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/evsc_step.sv
`default_nettype none
module evsc_step (
	input  wire evsc_pkg::cfg_t   regs,
	input  wire evsc_pkg::item_t  item,
	input  wire evsc_pkg::state_t cur,
	output evsc_pkg::state_t      nxt,
	output logic [3:0]            action
);

	function automatic logic [9:0] sat_add(input logic [9:0] a, input logic [9:0] b);
		logic [10:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, evsc_pkg::OpenMax}) ? evsc_pkg::OpenMax : s[9:0];
	endfunction

	function automatic logic [9:0] sat_sub(input logic [9:0] a, input logic [9:0] b);
		return (b >= a) ? 10'd0 : a - b;
	endfunction

	logic signed [13:0] err;
	logic               overtemp;

	// Superheat error spans 14 bits signed with the 9-bit target added.
	assign err = $signed({{2{item.measured_discharge_temp[11]}}, item.measured_discharge_temp})
		- $signed({{2{item.target_discharge_temp[11]}}, item.target_discharge_temp})
		+ $signed({5'b00000, regs.superheat_target});

	assign overtemp = $signed({item.measured_discharge_temp[11], item.measured_discharge_temp})
		> $signed({2'b00, regs.discharge_temp_limit});

	always_comb begin
		nxt = cur;
		action = evsc_pkg::ActInBand;
		case (item.mode)
			evsc_pkg::ModeDirect: begin
				nxt.opening = (item.opening_setpoint > evsc_pkg::OpenMax) ?
					evsc_pkg::OpenMax : item.opening_setpoint;
				nxt.wait_active = 1'b0;
				nxt.wait_count = 16'd0;
				action = evsc_pkg::ActDirect;
			end
			evsc_pkg::ModeStartup: begin
				nxt.opening = evsc_pkg::StartupOpening;
				nxt.pumped_down = 1'b0;
				action = evsc_pkg::ActStartup;
			end
			evsc_pkg::ModePumpDown: begin
				nxt.opening = 10'd0;
				nxt.pumped_down = 1'b1;
				action = evsc_pkg::ActPumpDown;
			end
			default: begin
				if (overtemp) begin
					nxt.opening = sat_add(cur.opening, evsc_pkg::OvertempStep);
					nxt.wait_active = 1'b0;
					nxt.wait_count = 16'd0;
					action = evsc_pkg::ActOvertemp;
				end else if (err < 14'(regs.critical_low_limit)) begin
					nxt.opening = sat_sub(cur.opening, regs.critical_close_step);
					nxt.wait_active = 1'b0;
					nxt.wait_count = 16'd0;
					action = evsc_pkg::ActCriticalLow;
				end else if (cur.wait_active) begin
					// A count of zero or one ends the wait on this tick.
					if (cur.wait_count <= 16'd1) begin
						nxt.wait_count = 16'd0;
						nxt.wait_active = 1'b0;
					end else begin
						nxt.wait_count = cur.wait_count - 16'd1;
					end
					action = evsc_pkg::ActWaiting;
				end else if (err >= 14'(regs.high_limit)) begin
					nxt.opening = sat_add(cur.opening, evsc_pkg::FineStep);
					nxt.wait_count = regs.wait_after_open;
					nxt.wait_active = 1'b1;
					action = evsc_pkg::ActOpened;
				end else if (err < 14'(regs.low_limit)) begin
					nxt.opening = sat_sub(cur.opening, evsc_pkg::FineStep);
					nxt.wait_count = regs.wait_after_close;
					nxt.wait_active = 1'b1;
					action = evsc_pkg::ActClosed;
				end
			end
		endcase
	end

endmodule
`default_nettype wire
